// ===== rtl/core/lspe_pkg.sv =====
// Package for the LED strip pattern engine.
// Holds pattern mode codes, register indexes and controller/datapath structs.
package lspe_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_RAINBOW = 3'd1,
    MODE_CHASE   = 3'd2,
    MODE_WIPE    = 3'd3,
    MODE_SCANNER = 3'd4,
    MODE_FADE    = 3'd5,
    MODE_OFF     = 3'd6,
    MODE_STATIC  = 3'd7
  } mode_e;

  localparam logic [CfgIdxW-1:0] REG_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DIR      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FIRST    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SECOND   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FADE     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COUNT    = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch frame parameters, start fade divides
    logic wipe_wr;    // paint wipe pixel
    logic pix_rd;     // read pixel store for current pixel
    logic pix_wr;     // compute and write pixel, present result
    logic advance;    // step index update
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic last_pix;
  } dp_sts_t;

endpackage

// ===== rtl/core/lspe_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the datapath for fade blends and rainbow offsets.
module lspe_divider #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (!trial[DW]) begin
        rem_q <= trial;
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/lspe_datapath.sv =====
// Datapath: config registers, step index, pixel store and color logic.
// Depends on lspe_pkg and lspe_divider.
module lspe_datapath #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [23:0]             cfg_data_i,
  input  logic                    tick_i,
  input  logic [7:0]              elapsed_i,
  output logic                    fire_o,
  input  lspe_pkg::dp_cmd_t       cmd_i,
  output lspe_pkg::dp_sts_t       sts_o,
  output logic [5:0]              pix_index_o,
  output logic [23:0]             pix_color_o,
  output logic                    pix_last_o,
  output logic                    done_o
);
  import lspe_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PIXELS);

  mode_e       mode_q;
  logic        dir_q;
  logic [7:0]  interval_q;
  logic [23:0] first_q, second_q;
  logic [15:0] fade_q;
  logic [6:0]  count_q;
  logic [15:0] step_q, tsu_q;
  logic [16:0] tsu_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE; dir_q <= 1'b0; interval_q <= '0;
      first_q <= '0; second_q <= '0; fade_q <= 16'd1; count_q <= 7'd24;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:     mode_q     <= mode_e'(cfg_data_i[2:0]);
        REG_DIR:      dir_q      <= cfg_data_i[0];
        REG_INTERVAL: interval_q <= cfg_data_i[7:0];
        REG_FIRST:    first_q    <= cfg_data_i;
        REG_SECOND:   second_q   <= cfg_data_i;
        REG_FADE:     fade_q     <= cfg_data_i[15:0];
        REG_COUNT:    count_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign tsu_sum = {1'b0, tsu_q} + {9'd0, elapsed_i};
  logic [15:0] tsu_sat;
  assign tsu_sat = tsu_sum[16] ? 16'hFFFF : tsu_sum[15:0];
  logic exceed;
  assign exceed = tsu_sat > {8'd0, interval_q};
  assign fire_o = tick_i && exceed && (mode_q != MODE_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tsu_q <= '0;
    else if (tick_i) tsu_q <= exceed ? 16'd0 : tsu_sat;
  end

  // frame parameters
  logic [6:0]  n_c;
  logic [16:0] s_c;
  assign n_c = (count_q < 7'd2) ? 7'd2 :
               (count_q > 7'(MAX_PIXELS)) ? 7'(MAX_PIXELS) : count_q;
  always_comb begin
    case (mode_q)
      MODE_RAINBOW: s_c = 17'd255;
      MODE_SCANNER: s_c = {9'd0, n_c, 1'b0} - 17'd2;
      MODE_FADE:    s_c = (fade_q == '0) ? 17'd1 : {1'b0, fade_q};
      default:      s_c = {10'd0, n_c};
    endcase
  end

  logic wipe_hit;
  assign wipe_hit = cmd_i.wipe_wr && ({1'b0, step_q} < {10'd0, n_c});

  // step index mod 3 by reciprocal multiply
  logic [32:0] m3_prod;
  logic [15:0] m3_quo;
  logic [17:0] m3_rem;
  assign m3_prod = {17'd0, step_q} * 33'd43691;
  assign m3_quo  = m3_prod[32:17];
  assign m3_rem  = {2'd0, step_q} - ({1'b0, m3_quo, 1'b0} + {2'd0, m3_quo});

  logic [6:0]  n_q;
  logic [16:0] s_q;
  logic [15:0] w_q;
  logic [1:0]  ch_q;          // fade channel being divided
  logic        fade_run_q;
  logic [23:0] fade_col_q;
  logic [5:0]  pix_q;
  logic [1:0]  mod3_q;        // (pix + idx) % 3
  logic [23:0] rd_q;
  logic [23:0] color_c;

  logic [23:0] store [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] vld_q;  // pixel written since reset

  // shared divider: fade channels in fade mode, rainbow offsets per pixel in rainbow mode
  logic        div_start, div_busy;
  logic [23:0] div_num, div_quo;
  logic [15:0] div_den;
  lspe_divider #(.NW(24), .DW(16)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  logic [7:0] ca, cb;
  always_comb begin
    case (ch_q)
      2'd0:    begin ca = first_q[23:16]; cb = second_q[23:16]; end
      2'd1:    begin ca = first_q[15:8];  cb = second_q[15:8];  end
      default: begin ca = first_q[7:0];   cb = second_q[7:0];   end
    endcase
  end
  logic [15:0] sw;
  logic [23:0] blend_num;
  logic [23:0] pa, pb;
  assign sw = s_q[15:0] - w_q;
  assign pa = {16'd0, ca} * {8'd0, sw};
  assign pb = {16'd0, cb} * {8'd0, w_q};
  assign blend_num = pa + pb;

  logic fade_issue_q;

  always_comb begin
    div_start = 1'b0; div_num = blend_num; div_den = s_q[15:0];
    if (fade_run_q && !div_busy && !fade_issue_q) begin
      div_start = 1'b1;
    end else if (cmd_i.pix_rd && mode_q == MODE_RAINBOW) begin
      div_start = 1'b1;
      div_num   = {10'd0, pix_q, 8'd0};
      div_den   = {9'd0, n_q};
    end
  end

  logic [15:0] w_c;
  assign w_c = ({1'b0, step_q} > s_c) ? s_c[15:0] : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_run_q <= 1'b0; fade_issue_q <= 1'b0;
    end else if (cmd_i.start) begin
      fade_run_q <= (mode_q == MODE_FADE); fade_issue_q <= 1'b0;
    end else if (fade_run_q) begin
      if (!div_busy && !fade_issue_q) fade_issue_q <= 1'b1;
      else if (!div_busy && fade_issue_q) begin
        fade_issue_q <= 1'b0;
        if (ch_q == 2'd2) fade_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (wipe_hit) vld_q[step_q[AW-1:0]] <= 1'b1;
      if (cmd_i.pix_wr) vld_q[pix_q[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q <= n_c; s_q <= s_c; w_q <= w_c; ch_q <= 2'd0;
      pix_q <= '0; mod3_q <= m3_rem[1:0];
    end else if (fade_run_q && !div_busy && fade_issue_q) begin
      case (ch_q)
        2'd0:    fade_col_q[23:16] <= div_quo[7:0];
        2'd1:    fade_col_q[15:8]  <= div_quo[7:0];
        default: fade_col_q[7:0]   <= div_quo[7:0];
      endcase
      ch_q <= ch_q + 2'd1;
    end
    if (cmd_i.pix_rd) rd_q <= vld_q[pix_q[AW-1:0]] ? store[pix_q[AW-1:0]] : '0;
    if (wipe_hit)
      store[step_q[AW-1:0]] <= first_q;
    if (cmd_i.pix_wr) begin
      store[pix_q[AW-1:0]] <= color_c;
      pix_index_o <= pix_q;
      pix_color_o <= color_c;
      pix_last_o  <= ({1'b0, pix_q} == n_q - 7'd1);
      pix_q  <= pix_q + 6'd1;
      mod3_q <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
    end
  end

  // wheel color
  logic [7:0]  pos, p, pr;
  logic [9:0]  p3;
  logic [23:0] wheel;
  assign pos = div_quo[7:0] + step_q[7:0];
  assign p   = 8'd255 - pos;
  always_comb begin
    if (p < 8'd85) pr = p;
    else if (p < 8'd170) pr = p - 8'd85;
    else pr = p - 8'd170;
    p3 = {2'd0, pr} * 10'd3;
    if (p < 8'd85) wheel = {8'd255 - p3[7:0], 8'd0, p3[7:0]};
    else if (p < 8'd170) wheel = {8'd0, p3[7:0], 8'd255 - p3[7:0]};
    else wheel = {p3[7:0], 8'd255 - p3[7:0], 8'd0};
  end

  logic        hit;
  logic [16:0] mirror;
  assign mirror = s_q - {1'b0, step_q};
  assign hit = ({11'd0, pix_q} == {1'b0, step_q}) ||
               (!mirror[16] && mirror == {11'd0, pix_q});
  always_comb begin
    case (mode_q)
      MODE_RAINBOW: color_c = wheel;
      MODE_CHASE:   color_c = (mod3_q == 2'd0) ? first_q : second_q;
      MODE_SCANNER: color_c = hit ? first_q : {1'b0, rd_q[23:17], 1'b0, rd_q[15:9],
                                               1'b0, rd_q[7:1]};
      MODE_FADE:    color_c = fade_col_q;
      MODE_OFF:     color_c = '0;
      MODE_STATIC:  color_c = first_q;
      default:      color_c = rd_q;
    endcase
  end

  // step advance; the wrap flag is known at frame start
  logic [16:0] inc;
  assign inc = {1'b0, step_q} + 17'd1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0; done_o <= 1'b0;
    end else if (cmd_i.start) begin
      if (!dir_q) done_o <= (inc >= s_c);
      else done_o <= (step_q == '0) || ({1'b0, step_q} >= s_c);
    end else if (cmd_i.advance) begin
      if (!dir_q) begin
        if (inc >= s_q) step_q <= '0;
        else step_q <= inc[15:0];
      end else begin
        if (step_q == '0 || {1'b0, step_q} >= s_q) step_q <= 16'(s_q - 17'd1);
        else step_q <= step_q - 16'd1;
      end
    end
  end

  assign sts_o.div_busy = div_busy || fade_run_q;
  assign sts_o.last_pix = ({1'b0, pix_q} == n_q - 7'd1);
endmodule

// ===== rtl/core/lspe_ctrl.sv =====
// Controller: sequences one frame per update through the datapath.
// Depends on lspe_pkg.
module lspe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  lspe_pkg::dp_sts_t sts_i,
  input  logic              out_ready_i,
  output lspe_pkg::dp_cmd_t cmd_o,
  output logic              idle_o,
  output logic              out_valid_o
);
  import lspe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_READ, ST_WAIT, ST_WRITE, ST_SEND, ST_ADV
  } state_e;

  state_e state_q;
  logic   last_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.start   = (state_q == ST_IDLE) && fire_i;
    cmd_o.wipe_wr = cmd_o.start;
    cmd_o.pix_rd  = (state_q == ST_READ);
    cmd_o.pix_wr  = (state_q == ST_WRITE);
    cmd_o.advance = (state_q == ST_ADV);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_valid_o <= 1'b0; last_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE:  if (fire_i) state_q <= ST_PREP;
        ST_PREP:  if (!sts_i.div_busy) state_q <= ST_READ;
        ST_READ:  state_q <= ST_WAIT;
        ST_WAIT:  if (!sts_i.div_busy) state_q <= ST_WRITE;
        ST_WRITE: begin
          last_q <= sts_i.last_pix;
          state_q <= sts_i.last_pix ? ST_ADV : ST_SEND;
          out_valid_o <= !sts_i.last_pix;
        end
        ST_ADV: begin
          state_q <= ST_SEND; out_valid_o <= 1'b1;
        end
        ST_SEND: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          state_q <= last_q ? ST_IDLE : ST_READ;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign idle_o = (state_q == ST_IDLE);
endmodule

// ===== rtl/core/led_strip_pattern_engine.sv =====
// LED strip pattern engine top level.
// Channels: s_axis (elapsed_ms ticks), cfg write port, m_axis (pixel items).
// A tick whose accumulated time exceeds update_interval starts a frame unless
// the mode is none; the block then emits pixel_count items, clamped to
// 2..MAX_PIXELS (pixel 0 first, tlast on the last). Before the first pixel
// item the controller passes its prep, read, wait and write states; each
// pixel goes through read, wait, write and send, the last one through advance
// before send. Rainbow holds the wait state while the shared serial divider
// computes each pixel's offset; fade runs three channel divides on it in the
// prep state before the first pixel. A tick that starts no frame is simply
// taken. Ticks are not accepted while a frame is being emitted.
// Reset clears registers to their defaults, the step index, time
// accumulator, and marks every pixel of the store unwritten so it reads black.
// A stalled receiver holds the current pixel item; the frame waits with it.
module led_strip_pattern_engine #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // elapsed_ms
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_index[5:0], pixel_color[29:6], pad
  output logic        m_axis_tlast,   // frame_last
  output logic        m_axis_tuser    // cycle_done
);
  import lspe_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        fire, idle;
  logic [5:0]  pix_idx;
  logic [23:0] pix_col;

  assign s_axis_tready = idle;
  assign cfg_ready_o   = 1'b1;

  lspe_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .tick_i(s_axis_tvalid && idle), .elapsed_i(s_axis_tdata),
    .fire_o(fire), .cmd_i(cmd), .sts_o(sts),
    .pix_index_o(pix_idx), .pix_color_o(pix_col),
    .pix_last_o(m_axis_tlast), .done_o(m_axis_tuser)
  );

  lspe_ctrl u_ctrl (
    .clk_i, .rst_ni, .fire_i(fire), .sts_i(sts),
    .out_ready_i(m_axis_tready), .cmd_o(cmd), .idle_o(idle),
    .out_valid_o(m_axis_tvalid)
  );

  assign m_axis_tdata = {2'b00, pix_col, pix_idx};
endmodule

// ===== rtl/core/lspe_checker.sv =====
// Port-level checker for the LED strip pattern engine, bound to the top.
// Depends only on the top level's ports.
module lspe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");
  a_noin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("tick accepted mid frame");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("item after frame end");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:0] == 6'd0 |-> !m_axis_tlast)
    else $error("last on pixel zero");
endmodule

bind led_strip_pattern_engine lspe_checker u_chk (.*);
